### src/line_raster_frame_store_assert.svh
// assertion macros for the line raster frame store
`ifndef LINE_RASTER_FRAME_STORE_ASSERT_SVH
`define LINE_RASTER_FRAME_STORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LRFS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame store check failed");
`define LRFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame store check failed");
`else
`define LRFS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LRFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### src/lrfs_pkg.sv
// types and constants shared by the line raster frame store
package lrfs_pkg;

  localparam int X_W   = 10;
  localparam int Y_W   = 9;
  localparam int ERR_W = 13;

  localparam logic [7:0] BLANK_BYTE = 8'hFF;
  localparam logic [7:0] LEFT_BIT   = 8'h80;

  typedef logic [X_W-1:0] coord_x_t;
  typedef logic [Y_W-1:0] coord_y_t;
  typedef logic signed [ERR_W-1:0] err_t;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_PLOT  = 2'd1,
    ACT_LINE  = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef struct packed {
    action_t     action;
    coord_x_t    start_x;
    coord_y_t    start_y;
    coord_x_t    end_x;
    coord_y_t    end_y;
    logic [15:0] byte_index;
  } in_t;

  typedef struct packed {
    logic [7:0] panel_byte;
    logic       off_frame;
  } out_t;

  typedef struct packed {
    logic     load;
    logic     step;
    coord_x_t x0;
    coord_y_t y0;
    coord_x_t x1;
    coord_y_t y1;
  } step_ctrl_t;

  typedef struct packed {
    coord_x_t x;
    coord_y_t y;
    logic     at_end;
  } step_stat_t;

endpackage

### src/lrfs_frame_mem.sv
// single write port, single registered read port byte memory for the frame store
module lrfs_frame_mem #(
  parameter int DEPTH  = 48000,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/lrfs_stepper.sv
// bresenham stepper: holds the current pixel and error term, advances one pixel a step
module lrfs_stepper (
  input  logic                   clk,
  input  lrfs_pkg::step_ctrl_t   ctrl,
  output lrfs_pkg::step_stat_t   stat
);

  lrfs_pkg::coord_x_t x_r, x_nxt, x1_r, x1_nxt, dx_r, dx_nxt;
  lrfs_pkg::coord_y_t y_r, y_nxt, y1_r, y1_nxt, dy_r, dy_nxt;
  logic               sxn_r, sxn_nxt, syn_r, syn_nxt;
  lrfs_pkg::err_t     err_r, err_nxt;

  lrfs_pkg::coord_x_t dx_ld;
  lrfs_pkg::coord_y_t dy_ld;
  lrfs_pkg::err_t     dx_s, dy_s;
  logic               move_x, move_y;

  always_comb begin
    dx_ld = (ctrl.x1 > ctrl.x0) ? ctrl.x1 - ctrl.x0 : ctrl.x0 - ctrl.x1;
    dy_ld = (ctrl.y1 > ctrl.y0) ? ctrl.y1 - ctrl.y0 : ctrl.y0 - ctrl.y1;
    dx_s  = lrfs_pkg::err_t'({3'b000, dx_r});
    dy_s  = lrfs_pkg::err_t'({4'b0000, dy_r});
    move_x = err_r > -dx_s;
    move_y = err_r < dy_s;

    x_nxt   = x_r;
    y_nxt   = y_r;
    x1_nxt  = x1_r;
    y1_nxt  = y1_r;
    dx_nxt  = dx_r;
    dy_nxt  = dy_r;
    sxn_nxt = sxn_r;
    syn_nxt = syn_r;
    err_nxt = err_r;

    if (ctrl.load) begin
      x_nxt   = ctrl.x0;
      y_nxt   = ctrl.y0;
      x1_nxt  = ctrl.x1;
      y1_nxt  = ctrl.y1;
      dx_nxt  = dx_ld;
      dy_nxt  = dy_ld;
      sxn_nxt = !(ctrl.x0 < ctrl.x1);
      syn_nxt = !(ctrl.y0 < ctrl.y1);
      if (dx_ld > lrfs_pkg::coord_x_t'(dy_ld)) begin
        err_nxt = lrfs_pkg::err_t'({4'b0000, dx_ld[lrfs_pkg::X_W-1:1]});
      end else begin
        err_nxt = -lrfs_pkg::err_t'({5'b00000, dy_ld[lrfs_pkg::Y_W-1:1]});
      end
    end else if (ctrl.step) begin
      err_nxt = err_r - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);
      if (move_x) begin
        x_nxt = sxn_r ? x_r - 1'b1 : x_r + 1'b1;
      end
      if (move_y) begin
        y_nxt = syn_r ? y_r - 1'b1 : y_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    x1_r  <= x1_nxt;
    y1_r  <= y1_nxt;
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    sxn_r <= sxn_nxt;
    syn_r <= syn_nxt;
    err_r <= err_nxt;
  end

  assign stat.x      = x_r;
  assign stat.y      = y_r;
  assign stat.at_end = (x_r == x1_r) && (y_r == y1_r);

endmodule

### src/line_raster_frame_store.sv
// top level of the line raster frame store: sequencer, stepper and frame memory
//
// One transaction at a time; in_ready is high only while the sequencer is idle, and the
// result sits in an output register so the next transaction can be taken while it waits.
// After reset a clearing pass writes blank bytes over the whole store, one byte a cycle,
// ROW_BYTES * FRAME_HEIGHT bytes (48000 at the defaults), before the first transaction is
// taken. Clear runs the same sweep and replies. A read waits for the registered memory byte;
// an index outside the store is answered off frame. Plot and line go through the Bresenham
// stepper: address, memory read and write back through the single memory port for each pixel
// inside the frame, the address step alone for each pixel outside, then the result is handed over.
module line_raster_frame_store #(
  parameter int FRAME_WIDTH  = 800,
  parameter int FRAME_HEIGHT = 480
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lrfs_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lrfs_pkg::out_t  out_data
);

  `include "line_raster_frame_store_assert.svh"

  localparam int ROW_BYTES   = (FRAME_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * FRAME_HEIGHT;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
  localparam logic [16:0] STORE_BYTES_V = 17'(STORE_BYTES);
  localparam logic [16:0] ROW_BYTES_V   = 17'(ROW_BYTES);
  localparam logic [10:0] WIDTH_V       = 11'(FRAME_WIDTH);
  localparam logic [9:0]  HEIGHT_V      = 10'(FRAME_HEIGHT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RD_WAIT,
    ST_PIX_ADDR,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_RESP
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              clr_reply_r, clr_reply_nxt;
  logic              off_r, off_nxt;
  logic [7:0]        pbyte_r, pbyte_nxt;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;
  logic [6:0]        xbyte_r, xbyte_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  lrfs_pkg::out_t    out_data_r, out_data_nxt;

  lrfs_pkg::step_ctrl_t step_ctrl;
  lrfs_pkg::step_stat_t step_stat;

  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [7:0]        mem_wr_data;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [7:0]        mem_rd_data;

  logic              in_fire;
  logic              in_frame;
  logic [ADDR_W-1:0] pix_addr;

  lrfs_stepper u_stepper (
    .clk  (clk),
    .ctrl (step_ctrl),
    .stat (step_stat)
  );

  lrfs_frame_mem #(
    .DEPTH  (STORE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_frame = ({1'b0, step_stat.x} < WIDTH_V) && ({1'b0, step_stat.y} < HEIGHT_V);
  assign pix_addr = row_base_r + ADDR_W'(xbyte_r);

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    clr_reply_nxt = clr_reply_r;
    off_nxt       = off_r;
    pbyte_nxt     = pbyte_r;
    row_base_nxt  = row_base_r;
    xbyte_nxt     = xbyte_r;
    bit_nxt       = bit_r;
    addr_nxt      = addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    step_ctrl.load = 1'b0;
    step_ctrl.step = 1'b0;
    step_ctrl.x0   = in_data.start_x;
    step_ctrl.y0   = in_data.start_y;
    step_ctrl.x1   = (in_data.action == lrfs_pkg::ACT_LINE) ? in_data.end_x : in_data.start_x;
    step_ctrl.y1   = (in_data.action == lrfs_pkg::ACT_LINE) ? in_data.end_y : in_data.start_y;

    mem_wr_en   = 1'b0;
    mem_wr_addr = addr_r;
    mem_wr_data = mem_rd_data & ~(lrfs_pkg::LEFT_BIT >> bit_r);
    mem_rd_en   = 1'b0;
    mem_rd_addr = pix_addr;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          off_nxt   = 1'b0;
          pbyte_nxt = '0;
          unique case (in_data.action)
            lrfs_pkg::ACT_CLEAR: begin
              clr_addr_nxt  = '0;
              clr_reply_nxt = 1'b1;
              state_nxt     = ST_CLEAR;
            end
            lrfs_pkg::ACT_PLOT, lrfs_pkg::ACT_LINE: begin
              step_ctrl.load = 1'b1;
              state_nxt      = ST_PIX_ADDR;
            end
            lrfs_pkg::ACT_READ: begin
              if ({1'b0, in_data.byte_index} < STORE_BYTES_V) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = in_data.byte_index[ADDR_W-1:0];
                state_nxt   = ST_RD_WAIT;
              end else begin
                off_nxt   = 1'b1;
                state_nxt = ST_RESP;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        mem_wr_en    = 1'b1;
        mem_wr_addr  = clr_addr_r;
        mem_wr_data  = lrfs_pkg::BLANK_BYTE;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = clr_reply_r ? ST_RESP : ST_IDLE;
        end
      end
      ST_RD_WAIT: begin
        pbyte_nxt = ~mem_rd_data;
        state_nxt = ST_RESP;
      end
      ST_PIX_ADDR: begin
        if (in_frame) begin
          row_base_nxt = ADDR_W'(17'(step_stat.y) * ROW_BYTES_V);
          xbyte_nxt    = step_stat.x[lrfs_pkg::X_W-1:3];
          bit_nxt      = step_stat.x[2:0];
          state_nxt    = ST_PIX_RD;
        end else begin
          off_nxt = 1'b1;
          if (step_stat.at_end) begin
            state_nxt = ST_RESP;
          end else begin
            step_ctrl.step = 1'b1;
          end
        end
      end
      ST_PIX_RD: begin
        mem_rd_en = 1'b1;
        addr_nxt  = pix_addr;
        state_nxt = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        mem_wr_en = 1'b1;
        if (step_stat.at_end) begin
          state_nxt = ST_RESP;
        end else begin
          step_ctrl.step = 1'b1;
          state_nxt      = ST_PIX_ADDR;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.panel_byte = pbyte_r;
          out_data_nxt.off_frame  = off_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_reply_r <= clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
    end
    off_r      <= off_nxt;
    pbyte_r    <= pbyte_nxt;
    row_base_r <= row_base_nxt;
    xbyte_r    <= xbyte_nxt;
    bit_r      <= bit_nxt;
    addr_r     <= addr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LRFS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ready)
  `LRFS_ASSERT_SAME(a_pixel_write_in_store, clk, rst_n, state_r == ST_PIX_WR,
                    {1'b0, mem_wr_addr} < (ADDR_W + 1)'(STORE_BYTES))
  `LRFS_ASSERT_NEXT(a_resp_waits, clk, rst_n,
                    state_r == ST_RESP && out_valid_r && !out_ready, state_r == ST_RESP)
  `LRFS_ASSERT_SAME(a_no_mem_clash, clk, rst_n, mem_wr_en, !mem_rd_en)

endmodule

### test/tb_top.sv
// testbench for the line raster frame store: random plot, line, read and clear traffic
module tb_top;

  localparam int FRAME_W     = 800;
  localparam int FRAME_H     = 480;
  localparam int ROW_BYTES   = (FRAME_W + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * FRAME_H;
  localparam int RANDOM_CMDS = 370;
  localparam int MAX_GAP     = 8;
  localparam int MAX_STALL   = 12;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  lrfs_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  lrfs_pkg::out_t out_data;

  logic [7:0]     frame_image [STORE_BYTES];
  lrfs_pkg::in_t  draw_cmds [$];
  lrfs_pkg::out_t expected_replies [$];
  int             read_targets [$];
  lrfs_pkg::out_t want;
  logic           in_taken;
  int             mismatch_count;
  int             burst_left;
  int             gap_left;
  int             ready_left;
  int             stall_left;
  longint         cycle_count;
  longint         cycle_limit;
  longint         cycle_budget;

  line_raster_frame_store #(
    .FRAME_WIDTH (FRAME_W),
    .FRAME_HEIGHT(FRAME_H)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  function automatic logic mark_pixel(int x, int y);
    if (x >= FRAME_W || y >= FRAME_H) return 1'b1;
    frame_image[y * ROW_BYTES + x / 8] &= ~(lrfs_pkg::LEFT_BIT >> (x % 8));
    return 1'b0;
  endfunction

  function automatic logic trace_line(int x0, int y0, int x1, int y1);
    int   dx;
    int   dy;
    int   step_x;
    int   step_y;
    int   err;
    int   e2;
    int   n;
    logic off;
    dx     = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy     = (y1 > y0) ? y1 - y0 : y0 - y1;
    step_x = (x0 < x1) ? 1 : -1;
    step_y = (y0 < y1) ? 1 : -1;
    err    = ((dx > dy) ? dx : -dy) / 2;
    off    = 1'b0;
    for (n = 0; n < 4096; n++) begin
      if (mark_pixel(x0, y0)) off = 1'b1;
      if (x0 == x1 && y0 == y1) break;
      e2 = err;
      if (e2 > -dx) begin
        err -= dy;
        x0  += step_x;
      end
      if (e2 < dy) begin
        err += dx;
        y0  += step_y;
      end
    end
    return off;
  endfunction

  function automatic lrfs_pkg::out_t apply_command(lrfs_pkg::in_t c);
    lrfs_pkg::out_t r;
    r = '0;
    case (c.action)
      lrfs_pkg::ACT_CLEAR: begin
        foreach (frame_image[i]) frame_image[i] = lrfs_pkg::BLANK_BYTE;
      end
      lrfs_pkg::ACT_PLOT: begin
        r.off_frame = mark_pixel(c.start_x, c.start_y);
      end
      lrfs_pkg::ACT_LINE: begin
        r.off_frame = trace_line(c.start_x, c.start_y, c.end_x, c.end_y);
      end
      default: begin
        if (c.byte_index < STORE_BYTES) r.panel_byte = ~frame_image[c.byte_index];
        else r.off_frame = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic lrfs_pkg::in_t make_cmd(lrfs_pkg::action_t act, int sx, int sy,
                                             int ex, int ey, int idx);
    lrfs_pkg::in_t c;
    c.action     = act;
    c.start_x    = lrfs_pkg::coord_x_t'(sx);
    c.start_y    = lrfs_pkg::coord_y_t'(sy);
    c.end_x      = lrfs_pkg::coord_x_t'(ex);
    c.end_y      = lrfs_pkg::coord_y_t'(ey);
    c.byte_index = 16'(idx);
    return c;
  endfunction

  function automatic int clamp_coord(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void note_target(int x, int y);
    if (x < FRAME_W && y < FRAME_H) read_targets.push_back(y * ROW_BYTES + x / 8);
  endfunction

  // adds worst-case block cycles for one transaction, with sender gap and receiver stall, to the budget and queues it
  function automatic void queue_cmd(lrfs_pkg::in_t c);
    int dx;
    int dy;
    int busy;
    dx = (c.end_x > c.start_x) ? c.end_x - c.start_x : c.start_x - c.end_x;
    dy = (c.end_y > c.start_y) ? c.end_y - c.start_y : c.start_y - c.end_y;
    case (c.action)
      lrfs_pkg::ACT_CLEAR: busy = STORE_BYTES + 1;
      lrfs_pkg::ACT_PLOT:  busy = 4;
      lrfs_pkg::ACT_LINE:  busy = 3 * (((dx > dy) ? dx : dy) + 1) + 1;
      default:             busy = 3;
    endcase
    cycle_budget += busy + MAX_GAP + MAX_STALL + 4;
    draw_cmds.push_back(c);
  endfunction

  // sender: bursts of transactions separated by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (draw_cmds.size() > 0) begin
        in_data  <= draw_cmds.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: ready runs broken by stalls
  always @(negedge clk) begin
    if (ready_left > 0) begin
      out_ready  <= 1'b1;
      ready_left <= ready_left - 1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      ready_left <= $urandom_range(1, 40);
      stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_STALL);
    end
  end

  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        $error("panel_byte: expected no transaction, actual %0h", out_data.panel_byte);
        mismatch_count++;
      end else begin
        want = expected_replies.pop_front();
        if (out_data.panel_byte !== want.panel_byte) begin
          $error("panel_byte: expected %0h, actual %0h", want.panel_byte, out_data.panel_byte);
          mismatch_count++;
        end
        if (out_data.off_frame !== want.off_frame) begin
          $error("off_frame: expected %0d, actual %0d", want.off_frame, out_data.off_frame);
          mismatch_count++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) expected_replies.push_back(apply_command(in_data));
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    lrfs_pkg::in_t cmd;
    int            n;
    int            pick;
    int            sel;
    int            ax;
    int            ay;
    int            clears_left;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    in_taken       = 1'b0;
    mismatch_count = 0;
    burst_left     = 0;
    gap_left       = 0;
    ready_left     = 0;
    stall_left     = 0;
    cycle_count    = 0;
    cycle_budget   = 0;
    cycle_limit    = 64'h7fff_ffff_ffff;
    foreach (frame_image[i]) frame_image[i] = lrfs_pkg::BLANK_BYTE;

    // corners, off-frame pixels, out-of-store reads, lines in several directions
    queue_cmd(make_cmd(lrfs_pkg::ACT_READ, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(lrfs_pkg::ACT_PLOT, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(lrfs_pkg::ACT_READ, 0, 0, 0, 0, 0));
    queue_cmd(make_cmd(lrfs_pkg::ACT_PLOT, FRAME_W - 1, FRAME_H - 1, 0, 0, 0));
    queue_cmd(make_cmd(lrfs_pkg::ACT_READ, 0, 0, 0, 0, STORE_BYTES - 1));
    queue_cmd(make_cmd(lrfs_pkg::ACT_PLOT, FRAME_W, 0, 0, 0, 0));
    queue_cmd(make_cmd(lrfs_pkg::ACT_PLOT, 0, FRAME_H, 0, 0, 0));
    queue_cmd(make_cmd(lrfs_pkg::ACT_PLOT, 1023, 511, 1023, 511, 65535));
    queue_cmd(make_cmd(lrfs_pkg::ACT_READ, 1023, 511, 1023, 511, STORE_BYTES));
    queue_cmd(make_cmd(lrfs_pkg::ACT_READ, 0, 0, 0, 0, 65535));
    queue_cmd(make_cmd(lrfs_pkg::ACT_LINE, 0, 1, FRAME_W - 1, 1, 0));
    queue_cmd(make_cmd(lrfs_pkg::ACT_READ, 0, 0, 0, 0, ROW_BYTES));
    queue_cmd(make_cmd(lrfs_pkg::ACT_READ, 0, 0, 0, 0, 2 * ROW_BYTES - 1));
    queue_cmd(make_cmd(lrfs_pkg::ACT_LINE, 5, 10, 5, 20, 0));
    queue_cmd(make_cmd(lrfs_pkg::ACT_LINE, 30, 40, 10, 20, 0));
    queue_cmd(make_cmd(lrfs_pkg::ACT_LINE, 3, 100, 9, 130, 0));
    queue_cmd(make_cmd(lrfs_pkg::ACT_LINE, 50, 50, 50, 50, 0));
    queue_cmd(make_cmd(lrfs_pkg::ACT_READ, 0, 0, 0, 0, 50 * ROW_BYTES + 6));
    queue_cmd(make_cmd(lrfs_pkg::ACT_LINE, 790, 470, 1023, 511, 0));
    queue_cmd(make_cmd(lrfs_pkg::ACT_READ, 0, 0, 0, 0, STORE_BYTES - 1));
    queue_cmd(make_cmd(lrfs_pkg::ACT_LINE, 1023, 0, 780, 5, 0));
    queue_cmd(make_cmd(lrfs_pkg::ACT_LINE, 0, 0, 1023, 511, 0));
    queue_cmd(make_cmd(lrfs_pkg::ACT_CLEAR, 1023, 511, 1023, 511, 65535));
    queue_cmd(make_cmd(lrfs_pkg::ACT_READ, 0, 0, 0, 0, ROW_BYTES));
    queue_cmd(make_cmd(lrfs_pkg::ACT_READ, 0, 0, 0, 0, STORE_BYTES - 1));

    clears_left = 3;
    for (n = 0; n < RANDOM_CMDS; n++) begin
      cmd = make_cmd(lrfs_pkg::action_t'($urandom_range(0, 3)),
                     $urandom_range(0, 1023), $urandom_range(0, 511),
                     $urandom_range(0, 1023), $urandom_range(0, 511),
                     $urandom_range(0, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 2 && clears_left > 0) begin
        cmd.action = lrfs_pkg::ACT_CLEAR;
        clears_left--;
      end else if (pick < 30) begin
        cmd.action = lrfs_pkg::ACT_PLOT;
        if ($urandom_range(0, 3) != 0) begin
          cmd.start_x = lrfs_pkg::coord_x_t'($urandom_range(0, FRAME_W - 1));
          cmd.start_y = lrfs_pkg::coord_y_t'($urandom_range(0, FRAME_H - 1));
        end
        note_target(cmd.start_x, cmd.start_y);
      end else if (pick < 62) begin
        cmd.action = lrfs_pkg::ACT_LINE;
        // mostly short lines, some hanging over the frame edge
        if ($urandom_range(0, 9) != 0) begin
          ax = ($urandom_range(0, 4) == 0) ? $urandom_range(FRAME_W - 16, 1023)
                                           : $urandom_range(0, FRAME_W - 1);
          ay = ($urandom_range(0, 4) == 0) ? $urandom_range(FRAME_H - 16, 511)
                                           : $urandom_range(0, FRAME_H - 1);
          cmd.start_x = lrfs_pkg::coord_x_t'(ax);
          cmd.start_y = lrfs_pkg::coord_y_t'(ay);
          cmd.end_x   = lrfs_pkg::coord_x_t'(
                          clamp_coord(ax + int'($urandom_range(0, 30)) - 15, 1023));
          cmd.end_y   = lrfs_pkg::coord_y_t'(
                          clamp_coord(ay + int'($urandom_range(0, 30)) - 15, 511));
        end
        note_target(cmd.start_x, cmd.start_y);
        note_target(cmd.end_x, cmd.end_y);
      end else begin
        cmd.action = lrfs_pkg::ACT_READ;
        sel = $urandom_range(0, 99);
        if (sel < 60 && read_targets.size() > 0)
          cmd.byte_index = 16'(read_targets[$urandom_range(0, read_targets.size() - 1)]);
        else if (sel < 85)
          cmd.byte_index = 16'($urandom_range(0, STORE_BYTES - 1));
      end
      queue_cmd(cmd);
    end

    // allow for the clearing sweep after reset
    cycle_limit = 4 * (STORE_BYTES + cycle_budget) + 10000;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (draw_cmds.size() != 0 || (in_valid && !in_taken) || expected_replies.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/lrfs_pkg.sv
src/lrfs_frame_mem.sv
src/lrfs_stepper.sv
src/line_raster_frame_store.sv
test/tb_top.sv
